FILE: hdl/itra_pkg.sv
// Shared types, constants and helpers for the integer to radix ASCII converter.
package itra_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int VALUE_W       = 32;
	localparam int RADIX_W       = 6;
	localparam int DIGIT_W       = 6;
	localparam int CHAR_W        = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

	localparam logic FUNC_SIGNED = 1'b0;

	typedef struct packed {
		logic               func;
		logic [VALUE_W-1:0] value;
	} itra_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              last;
	} itra_out_t;

	// divider control: start a digit pass, optionally reloading the dividend
	typedef struct packed {
		logic start;
		logic load;
	} div_ctl_t;

	// divider status after a digit pass
	typedef struct packed {
		logic               done;
		logic               q_zero;
		logic [DIGIT_W-1:0] rem;
	} div_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} itra_state_t;

	// saturate the programmed base into 2..36
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) res = RADIX_MIN;
		if (r > RADIX_MAX) res = RADIX_MAX;
		return res;
	endfunction

	// digit value to lower-case ASCII
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d >= DIGIT_TEN)
			res = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		else
			res = CHAR_ZERO + CHAR_W'(d);
		return res;
	endfunction

endpackage

FILE: hdl/itra_div.sv
// Bit-serial restoring divider by the radix: one quotient bit per cycle.
module itra_div #(
	parameter int WORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  itra_pkg::div_ctl_t       ctl,
	input  logic [WORD_BITS-1:0]     load_value,
	input  logic [itra_pkg::RADIX_W-1:0] radix,
	output itra_pkg::div_stat_t      stat
);
	import itra_pkg::*;

	localparam int CntW = $clog2(WORD_BITS + 1);

	logic                 run_q;
	logic                 done_q;
	logic [CntW-1:0]      cnt_q;
	logic [WORD_BITS-1:0] q_q;
	logic [DIGIT_W-1:0]   r_q;
	logic                 nz_q;

	logic [DIGIT_W:0]     trial;
	logic                 qbit;
	logic [DIGIT_W-1:0]   r_next;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial  = {r_q, q_q[WORD_BITS-1]};
		qbit   = (trial >= {1'b0, radix});
		r_next = qbit ? DIGIT_W'(trial - {1'b0, radix}) : DIGIT_W'(trial);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= CntW'(WORD_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend/quotient shift register and remainder
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			if (ctl.load) q_q <= load_value;
			r_q  <= '0;
			nz_q <= 1'b0;
		end else if (run_q) begin
			q_q  <= {q_q[WORD_BITS-2:0], qbit};
			r_q  <= r_next;
			nz_q <= nz_q | qbit;
		end
	end

	assign stat.done   = done_q;
	assign stat.q_zero = !nz_q;
	assign stat.rem    = r_q;

endmodule

FILE: hdl/itra_stack.sv
// Digit LIFO: digits come out least significant last, so the text reads MSB first.
module itra_stack #(
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          pop,
	input  logic [itra_pkg::DIGIT_W-1:0]  din,
	output logic [itra_pkg::DIGIT_W-1:0]  dout,
	output logic [$clog2(WORD_BITS+1)-1:0] count
);
	import itra_pkg::*;

	localparam int CntW = $clog2(WORD_BITS + 1);

	logic [DIGIT_W-1:0] stk_q [WORD_BITS];
	logic [CntW-1:0]    cnt_q;

	// fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// shift in at the top on push, shift toward the top on pop
	always_ff @(posedge clk) begin
		if (push) begin
			stk_q[0] <= din;
			for (int i = 1; i < WORD_BITS; i++) stk_q[i] <= stk_q[i-1];
		end else if (pop) begin
			for (int i = 0; i < WORD_BITS - 1; i++) stk_q[i] <= stk_q[i+1];
		end
	end

	assign dout  = stk_q[0];
	assign count = cnt_q;

endmodule

FILE: hdl/integer_to_radix_ascii.sv
// Top level: integer to radix ASCII text converter.
//
//  channel  | signals                       | transfer when
//  ---------+-------------------------------+---------------------------
//  item     | start, busy, item             | start && !busy
//  result   | strobe, result                | strobe (one cycle, no stall)
//  config   | cfg_valid, cfg_ready, cfg_data| cfg_valid && cfg_ready
//
// Each digit takes one full pass of the bit-serial divider over all WORD_BITS
// dividend bits; a minus sign, when present, adds one character.
// Characters leave on consecutive cycles, the last one flagged; the receiver
// cannot stall them. busy is high from the accepted item until the last
// character is presented. Reset is asynchronous, active low; radix resets to 10.
module integer_to_radix_ascii #(
	parameter int WORD_BITS = itra_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  itra_pkg::itra_in_t            item,
	output logic                          strobe,
	output itra_pkg::itra_out_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [itra_pkg::RADIX_W-1:0]  cfg_data
);
	import itra_pkg::*;

	localparam int CntW     = $clog2(WORD_BITS + 1);
	localparam int CopyBits = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;

	itra_state_t          state_q, state_d;
	logic [RADIX_W-1:0]   radix_q;
	logic [RADIX_W-1:0]   radix_eff;
	logic                 neg_q, neg_d;
	logic                 strobe_q, strobe_d;
	itra_out_t            result_q, result_d;

	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] load_value;
	div_ctl_t             div_ctl;
	div_stat_t            div_stat;
	logic                 push, pop;
	logic [DIGIT_W-1:0]   top_digit;
	logic [CntW-1:0]      depth;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end
	assign radix_eff = clamp_radix(radix_q);

	// take the low word bits, negate for a signed negative decimal value
	always_comb begin
		word = '0;
		word[CopyBits-1:0] = item.value[CopyBits-1:0];
		neg_d = (item.func == FUNC_SIGNED) && (radix_eff == RADIX_DEC) && word[WORD_BITS-1];
		load_value = neg_d ? (~word + 1'b1) : word;
	end

	itra_div #(.WORD_BITS(WORD_BITS)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (div_ctl),
		.load_value (load_value),
		.radix      (radix_eff),
		.stat       (div_stat)
	);

	itra_stack #(.WORD_BITS(WORD_BITS)) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.din    (div_stat.rem),
		.dout   (top_digit),
		.count  (depth)
	);

	// sequencer: divide until the quotient is zero, then emit sign and digits
	always_comb begin
		state_d       = state_q;
		div_ctl.start = 1'b0;
		div_ctl.load  = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		strobe_d      = 1'b0;
		result_d      = result_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					div_ctl.start = 1'b1;
					div_ctl.load  = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					push = 1'b1;
					if (div_stat.q_zero)
						state_d = neg_q ? ST_SIGN : ST_EMIT;
					else
						div_ctl.start = 1'b1;
				end
			end
			ST_SIGN: begin
				strobe_d           = 1'b1;
				result_d.text_char = CHAR_MINUS;
				result_d.last      = 1'b0;
				state_d            = ST_EMIT;
			end
			ST_EMIT: begin
				pop                = 1'b1;
				strobe_d           = 1'b1;
				result_d.text_char = digit_to_ascii(top_digit);
				result_d.last      = (depth == CntW'(1));
				if (depth == CntW'(1)) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (state_q == ST_IDLE && start) neg_q <= neg_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// characters of one text leave back to back
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap inside a text");

	// the last character coincides with the block going idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("busy after last character");

	// no character in the cycle after an item transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("character right after item transfer");

endmodule

FILE: tb/tb_integer_to_radix_ascii.sv
// Self-checking testbench for the integer to radix ASCII converter.
`timescale 1ns / 100ps

module tb_integer_to_radix_ascii;
	import itra_pkg::*;

	// kinds of entries in the sender's work list
	typedef enum logic [1:0] {
		JOB_WORD,
		JOB_RADIX,
		JOB_DRAIN,
		JOB_PACE
	} job_kind_t;

	typedef struct {
		job_kind_t kind;
		itra_in_t  word;
		int        arg;
	} job_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	itra_in_t            item = '0;
	logic                strobe;
	itra_out_t           result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [RADIX_W-1:0]  cfg_data = RADIX_RESET;

	job_t                job_q[$];
	itra_out_t           text_q[$];
	logic [RADIX_W-1:0]  radix_now = RADIX_RESET;
	int                  idle_pct = 0;
	int                  fails = 0;
	bit                  drained = 1'b1;

	integer_to_radix_ascii i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.strobe   (strobe),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Expected characters of one word at the current base
	task automatic queue_text(input itra_in_t w);
		logic [RADIX_W-1:0] b;
		logic [31:0]        mag;
		logic [RADIX_W-1:0] rem;
		logic [CHAR_W-1:0]  digs[$];
		logic               neg;
		itra_out_t          c;
		b = radix_now;
		if (b < 6'd2) b = 6'd2;
		if (b > 6'd36) b = 6'd36;
		mag = w.value;
		neg = (w.func == FUNC_SIGNED) && (b == RADIX_DEC) && mag[31];
		if (neg) mag = -mag;
		// least significant digit first, so build the string from the front
		do begin
			rem = RADIX_W'(mag % b);
			digs.push_front(rem > 6'd9 ? CHAR_W'(CHAR_A + rem - 6'd10) : CHAR_W'(CHAR_ZERO + rem));
			mag = mag / b;
		end while (mag != 0);
		if (neg) begin
			c.text_char = CHAR_MINUS;
			c.last      = 1'b0;
			text_q.push_back(c);
		end
		foreach (digs[i]) begin
			c.text_char = digs[i];
			c.last      = (i == digs.size() - 1);
			text_q.push_back(c);
		end
	endtask

	// sampled away from the rising edge so the sender sees a settled count
	always @(negedge clk) drained = (text_q.size() == 0);

	// Sender: words and radix writes from the work list
	always @(posedge clk) begin : sender
		logic next_start;
		logic next_cfg;
		job_t head;
		next_start = start;
		next_cfg   = cfg_valid;
		if (arst_n) begin
			if (start && !busy) begin
				queue_text(item);
				next_start = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				radix_now = cfg_data;
				next_cfg  = 1'b0;
			end
			if (!next_start && !next_cfg && job_q.size() > 0) begin
				head = job_q[0];
				case (head.kind)
					JOB_WORD: begin
						if ($urandom_range(99) >= idle_pct) begin
							item <= head.word;
							next_start = 1'b1;
							void'(job_q.pop_front());
						end
					end
					// radix writes and drains only once the block has gone quiet
					JOB_RADIX: begin
						if (drained && !start && !cfg_valid && !busy) begin
							cfg_data <= RADIX_W'(head.arg);
							next_cfg = 1'b1;
							void'(job_q.pop_front());
						end
					end
					JOB_DRAIN: begin
						if (drained && !start && !busy)
							void'(job_q.pop_front());
					end
					JOB_PACE: begin
						idle_pct = head.arg;
						void'(job_q.pop_front());
					end
					default: void'(job_q.pop_front());
				endcase
			end
		end
		start     <= next_start;
		cfg_valid <= next_cfg;
	end

	// Receiver: every strobed character against the oldest expectation
	always @(posedge clk) begin : receiver
		itra_out_t want;
		if (arst_n && strobe) begin
			if (text_q.size() == 0) begin
				$error("unexpected character %h last %b", result.text_char, result.last);
				fails++;
			end else begin
				want = text_q.pop_front();
				if (result.text_char !== want.text_char) begin
					$error("text_char: expected %h, got %h", want.text_char, result.text_char);
					fails++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, result.last);
					fails++;
				end
			end
		end
	end

	task automatic put_word(input logic f, input logic [31:0] v);
		job_t j;
		j.kind       = JOB_WORD;
		j.word.func  = f;
		j.word.value = v;
		j.arg        = 0;
		job_q.push_back(j);
	endtask

	task automatic put_ctl(input job_kind_t k, input int a);
		job_t j;
		j.kind = k;
		j.word = '0;
		j.arg  = a;
		job_q.push_back(j);
	endtask

	// words biased toward the interesting corners
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = $urandom();
			1: v = $urandom_range(40);
			2: v = {1'b1, 31'($urandom())};
			3: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3) : 32'h7fff_ffff - $urandom_range(3);
			4: v = 32'hffff_ffff - $urandom_range(20);
			default: v = $urandom() >> $urandom_range(31);
		endcase
		return v;
	endfunction

	// Stimulus plan, then wait for the last character
	initial begin : main
		int pace_tab[3];
		pace_tab = '{38, 51, 0};

		put_ctl(JOB_PACE, pace_tab[0]);
		// reset base of ten: zero, sign handling, most negative word
		put_word(FUNC_SIGNED, 32'd0);
		put_word(1'b1, 32'd0);
		put_word(FUNC_SIGNED, 32'd9);
		put_word(FUNC_SIGNED, 32'd10);
		put_word(FUNC_SIGNED, 32'h7fff_ffff);
		put_word(FUNC_SIGNED, 32'h8000_0000);
		put_word(FUNC_SIGNED, 32'hffff_ffff);
		put_word(1'b1, 32'hffff_ffff);
		put_word(1'b1, 32'h8000_0000);
		// largest base, negative word outside base ten has no sign
		put_ctl(JOB_RADIX, 36);
		put_word(1'b1, 32'd35);
		put_word(FUNC_SIGNED, 32'd36);
		put_word(FUNC_SIGNED, 32'h8000_0000);
		put_word(1'b1, 32'hffff_ffff);
		// smallest base gives the longest text
		put_ctl(JOB_RADIX, 2);
		put_word(FUNC_SIGNED, 32'hffff_ffff);
		put_word(1'b1, 32'd1);
		// out-of-range bases saturate
		put_ctl(JOB_RADIX, 0);
		put_word(1'b1, 32'd5);
		put_ctl(JOB_RADIX, 1);
		put_word(FUNC_SIGNED, 32'd2);
		put_ctl(JOB_RADIX, 63);
		put_word(1'b1, 32'd35);
		put_ctl(JOB_RADIX, 37);
		put_word(FUNC_SIGNED, 32'd36);
		put_ctl(JOB_DRAIN, 0);

		// random part: three pacing phases, a new base every nine words
		for (int p = 0; p < 3; p++) begin
			if (p > 0) put_ctl(JOB_PACE, pace_tab[p]);
			for (int s = 0; s < 3; s++) begin
				if ($urandom_range(4) == 0)
					put_ctl(JOB_RADIX, $urandom_range(63));
				else
					put_ctl(JOB_RADIX, $urandom_range(36, 2));
				for (int n = 0; n < 9; n++) begin
					if (n == 5 && s == 1) put_ctl(JOB_DRAIN, 0);
					put_word(1'($urandom_range(1)), pick_value());
				end
			end
		end
		put_ctl(JOB_RADIX, int'(RADIX_DEC));
		put_word(FUNC_SIGNED, 32'h8000_0000);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (job_q.size() != 0 || start || cfg_valid || busy || text_q.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);

		if (text_q.size() != 0) begin
			$error("%0d characters never arrived", text_q.size());
			fails++;
		end
		if (fails == 0)
			$display("integer_to_radix_ascii regression: pass");
		else
			$display("integer_to_radix_ascii regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("integer_to_radix_ascii regression: fail");
		$finish;
	end

endmodule
